FILE: rtl/hbd_pkg.sv
// Shared types and constants for the HTTP body dechunker.
package hbd_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Configuration register indexes
   localparam logic CSR_CHUNKED_MODE   = 1'b0;
   localparam logic CSR_CONTENT_LENGTH = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEN_DATA,
      PH_LEN_DONE,
      PH_SIZE,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_END_CR,
      PH_END_LF,
      PH_CH_DONE,
      PH_ERR_FMT,
      PH_ERR_LONG,
      PH_ERR_OVF
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY   = 3'd0,
      ST_DONE   = 3'd1,
      ST_FORMAT = 3'd2,
      ST_LONG   = 3'd3,
      ST_OVF    = 3'd4,
      ST_BEYOND = 3'd5
   } status_type;

   typedef struct packed {
      logic       body_valid;
      logic [7:0] body_byte;
      status_type status;
   } result_type;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

FILE: rtl/http_body_dechunker.sv
// HTTP body dechunker: length and chunked body extraction, one byte per beat.
// A start beat (req_command = 1) opens a new body, latching the transfer
// coding from the chunked_mode register; byte beats (req_command = 0) are
// then passed out in length mode or parsed as hex size lines, data and CR LF
// framing in chunked mode. Every request beat yields exactly one response
// beat with a status code; framing and size errors are sticky until the next
// start. The block takes one beat per clock while req_stall is low; the
// framing state updates on each accepted beat, and rsp_ is driven from the
// output register. A two-entry output buffer (output register plus skid
// register) lets a new request be taken while a response waits on rsp_stall;
// req_stall rises only once both entries are full. SIZE_BITS sets the widest
// chunk size accepted before a size-overflow status is reported.
module http_body_dechunker #(
   parameter int SIZE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_body_valid,
   output logic [7:0]             rsp_body_byte,
   output hbd_pkg::status_type    rsp_status
);
   import hbd_pkg::*;

   localparam int REM_BITS = (SIZE_BITS > 32) ? SIZE_BITS : 32;

   logic                chunked_mode_ff;
   logic [31:0]         content_length_ff;
   phase_type           phase_ff, phase_in;
   logic [REM_BITS-1:0] remaining_ff, remaining_in;
   logic [3:0]          digit_count_ff, digit_count_in;

   result_type          res;
   result_type          out_ff, skid_ff;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                load_out, load_skid, out_free;

   logic                req_acc;
   logic [4:0]          hex;
   logic                size_ovf;

   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign hex       = hex_decode(req_data_byte);
   assign size_ovf  = remaining_ff[REM_BITS-1:SIZE_BITS-4] != '0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff   <= 1'b0;
         content_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHUNKED_MODE:   chunked_mode_ff   <= csr_data[0];
            CSR_CONTENT_LENGTH: content_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      digit_count_in = digit_count_ff;
      if (req_command) begin
         digit_count_in = '0;
         if (chunked_mode_ff) begin
            phase_in     = PH_SIZE;
            remaining_in = '0;
         end else if (content_length_ff == '0) begin
            phase_in     = PH_LEN_DONE;
            remaining_in = '0;
         end else begin
            phase_in     = PH_LEN_DATA;
            remaining_in = REM_BITS'(content_length_ff);
         end
      end else begin
         case (phase_ff)
            PH_LEN_DATA: begin
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == REM_BITS'(1)) phase_in = PH_LEN_DONE;
            end
            PH_LEN_DONE, PH_ERR_LONG: phase_in = PH_ERR_LONG;
            PH_SIZE: begin
               if (hex[4]) begin
                  if (size_ovf) begin
                     phase_in = PH_ERR_OVF;
                  end else begin
                     remaining_in = {remaining_ff[REM_BITS-5:0], hex[3:0]};
                     if (digit_count_ff != 4'hF) digit_count_in = digit_count_ff + 1'b1;
                  end
               end else if (req_data_byte == CHAR_CR && digit_count_ff != '0) begin
                  phase_in = PH_SIZE_LF;
               end else begin
                  phase_in = PH_ERR_FMT;
               end
            end
            PH_SIZE_LF: begin
               if (req_data_byte != CHAR_LF) phase_in = PH_ERR_FMT;
               else if (remaining_ff == '0)  phase_in = PH_END_CR;
               else                          phase_in = PH_DATA;
            end
            PH_DATA: begin
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == REM_BITS'(1)) phase_in = PH_DATA_CR;
            end
            PH_DATA_CR: phase_in = (req_data_byte == CHAR_CR) ? PH_DATA_LF : PH_ERR_FMT;
            PH_DATA_LF: begin
               if (req_data_byte == CHAR_LF) begin
                  phase_in       = PH_SIZE;
                  remaining_in   = '0;
                  digit_count_in = '0;
               end else begin
                  phase_in = PH_ERR_FMT;
               end
            end
            PH_END_CR: phase_in = (req_data_byte == CHAR_CR) ? PH_END_LF : PH_ERR_FMT;
            PH_END_LF: phase_in = (req_data_byte == CHAR_LF) ? PH_CH_DONE : PH_ERR_FMT;
            default: ;
         endcase
      end
   end

   // result for the accepted beat
   always_comb begin
      res.body_valid = 1'b0;
      res.body_byte  = '0;
      res.status     = ST_BUSY;
      if (req_command) begin
         if (!chunked_mode_ff && content_length_ff == '0) res.status = ST_DONE;
      end else begin
         case (phase_ff)
            PH_LEN_DATA: begin
               res.body_valid = 1'b1;
               res.body_byte  = req_data_byte;
               if (remaining_ff == REM_BITS'(1)) res.status = ST_DONE;
            end
            PH_LEN_DONE, PH_ERR_LONG: res.status = ST_LONG;
            PH_SIZE: begin
               if (hex[4]) begin
                  if (size_ovf) res.status = ST_OVF;
               end else if (!(req_data_byte == CHAR_CR && digit_count_ff != '0)) begin
                  res.status = ST_FORMAT;
               end
            end
            PH_SIZE_LF: if (req_data_byte != CHAR_LF) res.status = ST_FORMAT;
            PH_DATA: begin
               res.body_valid = 1'b1;
               res.body_byte  = req_data_byte;
            end
            PH_DATA_CR, PH_END_CR: if (req_data_byte != CHAR_CR) res.status = ST_FORMAT;
            PH_DATA_LF: if (req_data_byte != CHAR_LF) res.status = ST_FORMAT;
            PH_END_LF:  res.status = (req_data_byte == CHAR_LF) ? ST_DONE : ST_FORMAT;
            PH_ERR_FMT: res.status = ST_FORMAT;
            PH_ERR_OVF: res.status = ST_OVF;
            default:    res.status = ST_BEYOND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         remaining_ff   <= '0;
         digit_count_ff <= '0;
      end else if (req_acc) begin
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         digit_count_ff <= digit_count_in;
      end
   end

   // two-entry output buffer; skid fills only while the output register is held
   always_comb begin
      out_free      = !out_valid_ff || !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
            load_out      = 1'b1;
         end else begin
            out_valid_in = req_acc;
            load_out     = req_acc;
         end
      end else if (req_acc) begin
         skid_valid_in = 1'b1;
         load_skid     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) out_ff <= skid_valid_ff ? skid_ff : res;
      if (load_skid) skid_ff <= res;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_body_valid = out_ff.body_valid;
   assign rsp_body_byte  = out_ff.body_byte;
   assign rsp_status     = out_ff.status;

`ifndef SYNTH
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_body_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_body_valid) |-> (rsp_status == ST_BUSY || rsp_status == ST_DONE))
      else $error("payload beat carries an error status");

   a_no_byte_without_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_body_valid) |-> (rsp_body_byte == '0))
      else $error("non-payload beat carries a byte");

   a_fmt_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERR_FMT && !(req_acc && req_command)) |=> (phase_ff == PH_ERR_FMT))
      else $error("format error cleared without a start");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_LEN_DATA) |-> (remaining_ff != '0))
      else $error("data phase with zero bytes left");
`endif

endmodule
